/* rtl/core/rmsg_pkg.sv */
// Shared types and defaults for the running mean and standard deviation block.
`timescale 1ns / 1ps

package rmsg_pkg;

    localparam int COUNT_BITS_DEFAULT  = 16;
    localparam int SAMPLE_BITS_DEFAULT = 16;

    // 5.0 in signed Q8.8
    localparam int MEAN_THRESHOLD_RESET = 1280;

    typedef enum logic [1:0] {
        MODE_START    = 2'd0,
        MODE_SAMPLE   = 2'd1,
        MODE_PREEMPT  = 2'd2,
        MODE_RESERVED = 2'd3
    } item_mode_t;

    typedef enum logic [1:0] {
        STATUS_RUNNING   = 2'd0,
        STATUS_SUCCEEDED = 2'd1,
        STATUS_ABORTED   = 2'd2
    } goal_status_t;

    typedef enum logic {
        OP_DIV  = 1'b0,
        OP_SQRT = 1'b1
    } unit_op_t;

    typedef struct packed {
        logic     start;
        unit_op_t op;
    } unit_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_sts_t;

endpackage

/* rtl/core/rmsg_divsqrt.sv */
// Shared shift and subtract unit: restoring divide and digit-by-digit square root.
`timescale 1ns / 1ps

module rmsg_divsqrt #(
    parameter int COUNT_BITS  = rmsg_pkg::COUNT_BITS_DEFAULT,
    parameter int SAMPLE_BITS = rmsg_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  rmsg_pkg::unit_cmd_t                          cmd,
    input  logic [((COUNT_BITS > SAMPLE_BITS) ? COUNT_BITS : SAMPLE_BITS)+1:0] rem_init,
    input  logic [2*SAMPLE_BITS-1:0]                     bits_init,
    input  logic [COUNT_BITS:0]                          divisor,
    input  logic [$clog2(2*SAMPLE_BITS)-1:0]             steps,
    output rmsg_pkg::unit_sts_t                          sts,
    output logic [2*SAMPLE_BITS-1:0]                     q
);

    localparam int W  = ((COUNT_BITS > SAMPLE_BITS) ? COUNT_BITS : SAMPLE_BITS) + 2;
    localparam int BW = 2 * SAMPLE_BITS;
    localparam int CW = $clog2(2 * SAMPLE_BITS);

    logic [W-1:0]          rem_reg,  rem_next;
    logic [BW-1:0]         bits_reg, bits_next;
    logic [BW-1:0]         q_reg,    q_next;
    logic [CW-1:0]         cnt_reg,  cnt_next;
    rmsg_pkg::unit_op_t    op_reg,   op_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [W-1:0]          cand;
    logic [W-1:0]          trial;
    logic [W:0]            diff;
    logic                  ge;

    // one compare/subtract serves both operations
    always_comb begin
        unique case (op_reg)
            rmsg_pkg::OP_DIV: begin
                cand  = {rem_reg[W-2:0], bits_reg[BW-1]};
                trial = W'(divisor);
            end
            rmsg_pkg::OP_SQRT: begin
                cand  = {rem_reg[W-3:0], bits_reg[BW-1:BW-2]};
                trial = W'({q_reg, 2'b01});
            end
            default: begin
                cand  = '0;
                trial = '0;
            end
        endcase
        diff = {1'b0, cand} - {1'b0, trial};
        ge   = ~diff[W];
    end

    always_comb begin
        rem_next  = rem_reg;
        bits_next = bits_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (cmd.start) begin
            rem_next  = rem_init;
            bits_next = bits_init;
            q_next    = '0;
            cnt_next  = steps;
            op_next   = cmd.op;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = ge ? diff[W-1:0] : cand;
            bits_next = (op_reg == rmsg_pkg::OP_DIV) ? (bits_reg << 1) : (bits_reg << 2);
            q_next    = {q_reg[BW-2:0], ge};
            cnt_next  = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= rmsg_pkg::OP_DIV;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        bits_reg <= bits_next;
        q_reg    <= q_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign q        = q_reg;

endmodule

/* rtl/core/running_mean_stddev_goal.sv */
// Top level: running mean and standard deviation over a goal of samples.
// A sample taken while active passes through SQR, ACC, DIV1 (SAMPLE_BITS divide steps for the mean),
// MSQ, DIV2 (2*SAMPLE_BITS-1 divide steps for the mean of squares), DIFF, SQRT (SAMPLE_BITS root steps
// in the shared unit) and FIN. tready stays low until the result enters the output register, which
// waits while that register is full; other items are taken in IDLE. Reset (aresetn low, sync) clears
// goal, count and sums and sets the threshold to 5.0.
`timescale 1ns / 1ps

module running_mean_stddev_goal #(
    parameter int COUNT_BITS  = rmsg_pkg::COUNT_BITS_DEFAULT,
    parameter int SAMPLE_BITS = rmsg_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                                           aclk,
    input  logic                                           aresetn,
    input  logic                                           cfg_wr_en,
    input  logic [SAMPLE_BITS-1:0]                         cfg_wr_data,
    input  logic                                           s_axis_tvalid,
    output logic                                           s_axis_tready,
    // sample, goal_samples
    input  logic [((SAMPLE_BITS+COUNT_BITS+7)/8)*8-1:0]    s_axis_tdata,
    // mode
    input  logic [1:0]                                     s_axis_tuser,
    output logic                                           m_axis_tvalid,
    input  logic                                           m_axis_tready,
    // sample_number, sample_echo, mean, std_dev, status
    output logic [((COUNT_BITS+3*SAMPLE_BITS+3+7)/8)*8-1:0] m_axis_tdata
);

    localparam int SB     = SAMPLE_BITS;
    localparam int CB     = COUNT_BITS;
    localparam int OUT_F  = CB + 3 * SB + 3;
    localparam int OUT_W  = ((OUT_F + 7) / 8) * 8;
    localparam int SUM_W  = SB + CB + 1;
    localparam int SQ_W   = (2 * SB + CB - 1 > 64) ? 64 : 2 * SB + CB - 1;
    localparam int UW     = ((CB > SB) ? CB : SB) + 2;
    localparam int CW     = $clog2(2 * SB);

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_SQR  = 9'b000000010,
        ST_ACC  = 9'b000000100,
        ST_DIV1 = 9'b000001000,
        ST_MSQ  = 9'b000010000,
        ST_DIV2 = 9'b000100000,
        ST_DIFF = 9'b001000000,
        ST_SQRT = 9'b010000000,
        ST_FIN  = 9'b100000000
    } state_t;

    state_t                state_reg, state_next;
    logic                  active_reg, active_next;
    logic [CB:0]           count_reg, count_next;
    logic [CB-1:0]         goal_reg, goal_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [SQ_W-1:0]       sqsum_reg, sqsum_next;
    logic signed [SB-1:0]  thr_reg;
    logic [SB-1:0]         sample_reg, sample_next;
    logic [SB-1:0]         mag_reg, mag_next;
    logic [SB-1:0]         mean_reg, mean_next;
    logic [SB-1:0]         mmag_reg, mmag_next;
    logic [2*SB-1:0]       prod_reg, prod_next;

    logic                  out_valid_reg, out_valid_next;
    logic [CB:0]           out_count_reg;
    logic [SB-1:0]         out_sample_reg;
    logic [SB-1:0]         out_mean_reg;
    logic [SB-1:0]         out_sd_reg;
    logic [1:0]            out_status_reg;
    logic                  load_out;
    logic [1:0]            status_new;

    logic [1:0]            in_mode;
    logic [SB-1:0]         in_sample;
    logic [CB-1:0]         in_goal;
    logic                  in_xfer;

    logic [SB-1:0]         mul_a;
    logic [SUM_W-1:0]      abs_sum;
    logic [SB-1:0]         q_mag;
    logic [2*SB-1:0]       sq_diff;

    rmsg_pkg::unit_cmd_t   unit_cmd;
    rmsg_pkg::unit_sts_t   unit_sts;
    logic [UW-1:0]         unit_rem;
    logic [2*SB-1:0]       unit_bits;
    logic [CW-1:0]         unit_steps;
    logic [2*SB-1:0]       unit_q;

    assign in_mode   = s_axis_tuser;
    assign in_sample = s_axis_tdata[SB-1:0];
    assign in_goal   = s_axis_tdata[SB+CB-1:SB];
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer   = s_axis_tvalid && s_axis_tready;

    rmsg_divsqrt #(
        .COUNT_BITS  (COUNT_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_divsqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (unit_cmd),
        .rem_init  (unit_rem),
        .bits_init (unit_bits),
        .divisor   (count_reg),
        .steps     (unit_steps),
        .sts       (unit_sts),
        .q         (unit_q)
    );

    // one squarer, shared by the sample square and the mean square
    assign mul_a     = (state_reg == ST_SQR) ? mag_reg : mmag_reg;
    assign prod_next = ((state_reg == ST_SQR) || (state_reg == ST_MSQ)) ? mul_a * mul_a
                                                                        : prod_reg;

    assign abs_sum = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign q_mag   = unit_q[SB-1:0];
    assign sq_diff = (unit_q >= prod_reg) ? (unit_q - prod_reg) : (prod_reg - unit_q);

    // issue unit commands
    always_comb begin
        unit_cmd.start = 1'b0;
        unit_cmd.op    = rmsg_pkg::OP_DIV;
        unit_rem       = '0;
        unit_bits      = '0;
        unit_steps     = '0;
        if (state_reg == ST_ACC) begin
            unit_cmd.start = 1'b1;
            unit_rem       = UW'(abs_sum[SB+CB-1:SB]);
            unit_bits      = {abs_sum[SB-1:0], {SB{1'b0}}};
            unit_steps     = CW'(SB);
        end else if (state_reg == ST_MSQ) begin
            unit_cmd.start = 1'b1;
            unit_rem       = UW'(sqsum_reg[SQ_W-1:2*SB-1]);
            unit_bits      = {sqsum_reg[2*SB-2:0], 1'b0};
            unit_steps     = CW'(2 * SB - 1);
        end else if (state_reg == ST_DIFF) begin
            unit_cmd.start = 1'b1;
            unit_cmd.op    = rmsg_pkg::OP_SQRT;
            unit_bits      = sq_diff;
            unit_steps     = CW'(SB);
        end
    end

    always_comb begin
        if (count_reg > {1'b0, goal_reg}) begin
            status_new = ($signed(mean_reg) >= thr_reg) ? rmsg_pkg::STATUS_SUCCEEDED
                                                        : rmsg_pkg::STATUS_ABORTED;
        end else begin
            status_new = rmsg_pkg::STATUS_RUNNING;
        end
    end

    assign load_out = (state_reg == ST_FIN) && (!out_valid_reg || m_axis_tready);

    always_comb begin
        state_next  = state_reg;
        active_next = active_reg;
        count_next  = count_reg;
        goal_next   = goal_reg;
        sum_next    = sum_reg;
        sqsum_next  = sqsum_reg;
        sample_next = sample_reg;
        mag_next    = mag_reg;
        mean_next   = mean_reg;
        mmag_next   = mmag_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    unique case (in_mode)
                        rmsg_pkg::MODE_START: begin
                            count_next  = '0;
                            sum_next    = '0;
                            sqsum_next  = '0;
                            goal_next   = in_goal;
                            active_next = 1'b1;
                        end
                        rmsg_pkg::MODE_PREEMPT: begin
                            active_next = 1'b0;
                        end
                        rmsg_pkg::MODE_SAMPLE: begin
                            if (active_reg) begin
                                count_next  = count_reg + (CB+1)'(1);
                                sum_next    = sum_reg + {{(CB+1){in_sample[SB-1]}}, in_sample};
                                sample_next = in_sample;
                                mag_next    = in_sample[SB-1] ? -in_sample : in_sample;
                                state_next  = ST_SQR;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SQR: begin
                state_next = ST_ACC;
            end
            ST_ACC: begin
                sqsum_next = sqsum_reg + SQ_W'(prod_reg);
                state_next = ST_DIV1;
            end
            ST_DIV1: begin
                if (unit_sts.done) begin
                    mmag_next  = q_mag;
                    mean_next  = sum_reg[SUM_W-1] ? -q_mag : q_mag;
                    state_next = ST_MSQ;
                end
            end
            ST_MSQ: begin
                state_next = ST_DIV2;
            end
            ST_DIV2: begin
                if (unit_sts.done) begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF: begin
                state_next = ST_SQRT;
            end
            ST_SQRT: begin
                if (unit_sts.done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                // hold until the output register is free
                if (load_out) begin
                    if (status_new != rmsg_pkg::STATUS_RUNNING) begin
                        active_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
        if (load_out) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            active_reg    <= 1'b0;
            count_reg     <= '0;
            goal_reg      <= '0;
            sum_reg       <= '0;
            sqsum_reg     <= '0;
            thr_reg       <= SB'(rmsg_pkg::MEAN_THRESHOLD_RESET);
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            count_reg     <= count_next;
            goal_reg      <= goal_next;
            sum_reg       <= sum_next;
            sqsum_reg     <= sqsum_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                thr_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg <= sample_next;
        mag_reg    <= mag_next;
        mean_reg   <= mean_next;
        mmag_reg   <= mmag_next;
        prod_reg   <= prod_next;
        if (load_out) begin
            out_count_reg  <= count_reg;
            out_sample_reg <= sample_reg;
            out_mean_reg   <= mean_reg;
            out_sd_reg     <= unit_q[SB-1:0];
            out_status_reg <= status_new;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'({out_status_reg, out_sd_reg, out_mean_reg,
                                   out_sample_reg, out_count_reg});

    // the shared unit only runs while an item is in flight
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !unit_sts.busy)
        else $error("divide/sqrt unit busy while idle");

    assert property (@(posedge aclk) disable iff (!aresetn)
        unit_sts.done |-> (state_reg == ST_DIV1 || state_reg == ST_DIV2 ||
                           state_reg == ST_SQRT))
        else $error("unit finished outside a wait state");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (out_count_reg != '0))
        else $error("result carries zero sample count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (load_out && status_new != rmsg_pkg::STATUS_RUNNING) |=> !active_reg)
        else $error("goal finished but block still active");

endmodule
